// File: src/prac_pkg.sv
// Shared types and constants for the page reference-count allocator.
// Depends on nothing; prac_ctrl and the allocator core import it.
package prac_pkg;

    localparam int PAGE_COUNT_DEF     = 1024;
    localparam int RESERVED_PAGES_DEF = 256;
    localparam int PAGE_SHIFT         = 12;
    localparam int COUNT_W            = 8;
    localparam int IDX_IN_W           = 11;
    localparam int PAGE_OUT_W         = 10;
    localparam logic [COUNT_W-1:0] USED_MARK = 8'd100;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_RESERVED = 3'd2,
        ST_NOPAGE   = 3'd3,
        ST_DOUBLE   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic                  strobe;
        t_status               status;
        logic [PAGE_OUT_W-1:0] page;
    } t_result;

endpackage

// File: src/prac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module prac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/prac_ctrl.sv
// Sequencer for the allocator: restore pass, top-down allocation scan, free check.
// Depends on prac_pkg; drives the reference-count RAM ports.
module prac_ctrl import prac_pkg::*; #(
    parameter int PAGE_COUNT     = PAGE_COUNT_DEF,
    parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_mode,
    input  logic [IDX_IN_W-1:0]           i_page_index,
    input  logic [COUNT_W-1:0]            i_rdata,
    output logic                          o_we,
    output logic [$clog2(PAGE_COUNT)-1:0] o_waddr,
    output logic [COUNT_W-1:0]            o_wdata,
    output logic [$clog2(PAGE_COUNT)-1:0] o_raddr,
    output logic                          o_busy,
    output t_result                       o_result
);

    localparam int AW = $clog2(PAGE_COUNT);
    localparam bit HAS_POOL = PAGE_COUNT > RESERVED_PAGES;
    localparam logic [AW-1:0] TOP  = AW'(PAGE_COUNT - 1);
    localparam logic [AW-1:0] BASE = AW'(RESERVED_PAGES);

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic          r_chk_vld, n_chk_vld;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_init_pend, n_init_pend;

    logic [31:0]   idx32;
    logic [31:0]   addr32;
    logic [31:0]   chk32;
    logic          idx_reserved;
    logic          idx_missing;
    logic          scan_hit;
    logic          scan_last;
    logic          clear_last;
    t_mode         mode;

    assign mode         = t_mode'(i_mode);
    assign idx32        = 32'(i_page_index);
    assign addr32       = 32'(r_addr);
    assign chk32        = 32'(r_chk_addr);
    assign idx_reserved = idx32 < 32'(RESERVED_PAGES);
    assign idx_missing  = idx32 >= 32'(PAGE_COUNT);
    assign scan_hit     = r_chk_vld && (i_rdata == '0);
    assign scan_last    = r_chk_vld && (r_chk_addr == BASE);
    assign clear_last   = r_addr == TOP;

    // next state and sequencer registers
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_chk_addr  = r_chk_addr;
        n_chk_vld   = r_chk_vld;
        n_idx       = r_idx;
        n_init_pend = r_init_pend;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (clear_last) begin
                    n_state     = S_IDLE;
                    n_init_pend = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    case (mode)
                        MODE_INIT: begin
                            n_state     = S_CLEAR;
                            n_addr      = '0;
                            n_init_pend = 1'b1;
                        end
                        MODE_ALLOC: begin
                            if (HAS_POOL) begin
                                n_state   = S_SCAN;
                                n_addr    = TOP;
                                n_chk_vld = 1'b0;
                            end
                        end
                        MODE_FREE: begin
                            if (!idx_reserved && !idx_missing) begin
                                n_state = S_FREE;
                                n_idx   = AW'(idx32);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // keep one read in flight; rdata belongs to r_chk_addr
                n_addr     = r_addr - 1'b1;
                n_chk_addr = r_addr;
                n_chk_vld  = 1'b1;
                if (scan_hit || scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM controls and result
    always_comb begin
        o_we            = 1'b0;
        o_waddr         = r_addr;
        o_wdata         = '0;
        o_raddr         = r_addr;
        o_busy          = r_state != S_IDLE;
        o_result.strobe = 1'b0;
        o_result.status = ST_OK;
        o_result.page   = '0;
        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_wdata = (addr32 < 32'(RESERVED_PAGES)) ? USED_MARK : '0;
                if (clear_last && r_init_pend) begin
                    o_result.strobe = 1'b1;
                end
            end
            S_IDLE: begin
                o_raddr = AW'(idx32);
                if (i_accept) begin
                    case (mode)
                        MODE_ALLOC: begin
                            if (!HAS_POOL) begin
                                o_result.strobe = 1'b1;
                                o_result.status = ST_OOM;
                            end
                        end
                        MODE_FREE: begin
                            if (idx_reserved) begin
                                o_result.strobe = 1'b1;
                                o_result.status = ST_RESERVED;
                            end else if (idx_missing) begin
                                o_result.strobe = 1'b1;
                                o_result.status = ST_NOPAGE;
                            end
                        end
                        MODE_NOP: begin
                            o_result.strobe = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    o_we            = 1'b1;
                    o_waddr         = r_chk_addr;
                    o_wdata         = COUNT_W'(1);
                    o_result.strobe = 1'b1;
                    o_result.page   = chk32[PAGE_OUT_W-1:0];
                end else if (scan_last) begin
                    o_result.strobe = 1'b1;
                    o_result.status = ST_OOM;
                end
            end
            S_FREE: begin
                o_result.strobe = 1'b1;
                o_waddr         = r_idx;
                if (i_rdata == '0) begin
                    o_result.status = ST_DOUBLE;
                end else begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_chk_vld   <= 1'b0;
            r_init_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_chk_vld   <= n_chk_vld;
            r_init_pend <= n_init_pend;
        end
        r_chk_addr <= n_chk_addr;
        r_idx      <= n_idx;
    end

endmodule

// File: src/page_refcount_allocator_core.sv
// Page allocator with 8-bit reference counts. Reset and init run a restore pass over
// all PAGE_COUNT pages (1024 by default), busy throughout. Allocate: a top-down scan,
// one count read per cycle from the RAM port. Free: a count read, then a decrement or a
// double-free status; out-of-range free, unused mode: result the next cycle.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
module page_refcount_allocator_core import prac_pkg::*; #(
    parameter int PAGE_COUNT     = PAGE_COUNT_DEF,
    parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [IDX_IN_W-1:0]   i_page_index,
    output logic                  o_strobe,
    output logic [2:0]            o_status,
    output logic [PAGE_OUT_W-1:0] o_result_page
);

    localparam int AW = $clog2(PAGE_COUNT);

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] ram_rdata;
    t_result       result;
    logic          r_strobe;
    t_status       r_status;
    logic [PAGE_OUT_W-1:0] r_page;

    assign accept = start && !busy;

    prac_ctrl #(
        .PAGE_COUNT     (PAGE_COUNT),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_page_index (i_page_index),
        .i_rdata      (ram_rdata),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_raddr      (ram_raddr),
        .o_busy       (busy),
        .o_result     (result)
    );

    prac_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (PAGE_COUNT)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // register the result; it shows for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= result.strobe;
        end
        r_status <= result.status;
        r_page   <= result.page;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_result_page = r_page;

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("restore pass did not start after reset");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_strobe || busy))
        else $error("accepted item produced neither result nor work");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while sequencer still busy");

    a_page_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result_page != '0)) |-> (o_status == ST_OK))
        else $error("nonzero page on a failed item");

endmodule
